// File: hdl/lavm_pkg.sv
// shared types and constants for the look-at view matrix block
package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 2;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
        logic               degenerate;
    } t_out;

    // one queued job: the transaction plus the view direction
    typedef struct packed {
        t_in                item;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: hdl/look_at_view_matrix_top.sv
// back end: three normalisations share the 32-step square root and the one-bit-a-step divider,
//   which set how long a run takes; a normalisation that meets zero length skips both
// throughput: one transaction per back-end run; a two-deep job queue takes new ones meanwhile
// results: four rows on consecutive cycles, one cycle each; the receiver cannot stall
// reset: synchronous active-low clears the queue and the sequencer
module look_at_view_matrix_top
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    // front end to queue
    logic   push;
    t_job   job_in;
    // queue to back end
    t_qstat qstat;
    t_job   job_out;
    logic   pop;

    // front end: takes the transaction, works out target minus eye
    lavm_front u_front (
        .start   (start),
        .i_item  (i_item),
        .i_qstat (qstat),
        .busy    (busy),
        .o_push  (push),
        .o_job   (job_in)
    );

    // decouples acceptance from the long arithmetic run
    lavm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_job   (job_out)
    );

    // back end: normalisations, cross and dot products, row output
    lavm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // rows of one run follow each other on consecutive cycles
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_row |=> o_strobe &&
            o_result.row_index == $past(o_result.row_index) + 2'd1)
        else $error("row sequence broken");

    // the degenerate flag is the same on every row of a run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_row |=>
            o_result.degenerate == $past(o_result.degenerate))
        else $error("degenerate flag changed within a run");

    // last row marker only on row three
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.last_row == (o_result.row_index == 2'd3)))
        else $error("last row marker misplaced");

    // a run never starts right after its own last row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_row |=> !o_strobe)
        else $error("rows emitted without a new run");

endmodule

// File: hdl/lavm_front.sv
// front end: accepts a transaction and forms the view direction
module lavm_front
    import lavm_pkg::*;
(
    input  logic   start,
    input  t_in    i_item,
    input  t_qstat i_qstat,
    output logic   busy,
    output logic   o_push,
    output t_job   o_job
);

    assign busy   = i_qstat.full;
    assign o_push = start && !i_qstat.full;

    always_comb begin
        o_job.item = i_item;
        o_job.dx   = 33'(i_item.target_x) - 33'(i_item.eye_x);
        o_job.dy   = 33'(i_item.target_y) - 33'(i_item.eye_y);
        o_job.dz   = 33'(i_item.target_z) - 33'(i_item.eye_z);
    end

endmodule

// File: hdl/lavm_queue.sv
// short job queue between front end and back end
module lavm_queue
    import lavm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_job   o_job
);

    localparam int PW = $clog2(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_qstat.full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_job         = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: hdl/lavm_back.sv
// back end: sequencer with shared multiplier, bit-serial square root and divider
module lavm_back
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_qstat,
    input  t_job   i_job,
    output logic   o_pop,
    output logic   o_strobe,
    output t_out   o_result
);

    localparam int QW = FRAC_BITS + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ABS   = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_CROSS = 4'd6;
    localparam logic [3:0] S_ROUND = 4'd7;
    localparam logic [3:0] S_DOT   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_strobe, n_strobe;
    t_out       r_out, n_out;
    logic [1:0] r_phase, n_phase;
    logic [2:0] r_cnt, n_cnt;
    logic       r_sub, n_sub;
    logic [4:0] r_k, n_k;
    logic       r_deg, n_deg;

    logic signed [31:0] r_eye [3], n_eye [3];
    logic signed [31:0] r_wup [3], n_wup [3];
    logic signed [63:0] r_v [3], n_v [3];
    logic               r_neg [3], n_neg [3];
    logic        [63:0] r_m [3], n_m [3];
    logic        [63:0] r_x, n_x, r_res, n_res, r_rem, n_rem;
    logic        [31:0] r_s, n_s;
    logic      [QW-1:0] r_q, n_q;
    logic signed [31:0] r_look [3], n_look [3];
    logic signed [31:0] r_rgt [3], n_rgt [3];
    logic signed [31:0] r_upv [3], n_upv [3];
    logic signed [31:0] r_r2 [3], n_r2 [3];
    logic signed [31:0] r_dot [3], n_dot [3];
    logic signed [63:0] r_acc, n_acc, r_prod, n_prod;

    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic signed [32:0] va [3], vb [3], vd [3];
    logic        [63:0] mx, mabs [3], bitv, tdiv;
    logic signed [63:0] accn;
    logic        [31:0] qz;
    logic        [1:0]  ia, ib, ci;

    assign prod = op_a * op_b;

    // round half away from zero at the fraction point
    function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
        logic [63:0] u, r;
        u = p[63] ? 64'(-p) : 64'(p);
        r = (u + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[63] ? -$signed(r) : $signed(r);
    endfunction

    // rounded, negated and saturated dot product
    function automatic logic signed [31:0] negsat(input logic signed [63:0] p);
        logic [63:0] u, r;
        u = p[63] ? 64'(-p) : 64'(p);
        r = (u + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p[63]) begin
            return (r > 64'(SAT_MAX)) ? SAT_MAX : r[31:0];
        end
        return (r > 64'h8000_0000) ? SAT_MIN : 32'(64'(0) - r);
    endfunction

    // operand vectors of the cross product and dot product in use
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_phase)
                2'd0: begin
                    va[i] = 33'(r_wup[i]);
                    vb[i] = 33'(r_look[i]);
                    vd[i] = 33'(r_r2[i]);
                end
                2'd1: begin
                    va[i] = 33'(r_look[i]);
                    vb[i] = 33'(r_rgt[i]);
                    vd[i] = 33'(r_upv[i]);
                end
                default: begin
                    va[i] = 33'(r_upv[i]);
                    vb[i] = 33'(r_look[i]);
                    vd[i] = 33'(r_look[i]);
                end
            endcase
            mabs[i] = r_v[i][63] ? 64'(-r_v[i]) : 64'(r_v[i]);
        end
        case (r_cnt)
            3'd0:    begin ia = 2'd1; ib = 2'd2; end
            3'd1:    begin ia = 2'd2; ib = 2'd1; end
            3'd2:    begin ia = 2'd2; ib = 2'd0; end
            3'd3:    begin ia = 2'd0; ib = 2'd2; end
            3'd4:    begin ia = 2'd0; ib = 2'd1; end
            default: begin ia = 2'd1; ib = 2'd0; end
        endcase
        ci = 2'(r_cnt >> 1);
    end

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_out    = r_out;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_sub    = r_sub;
        n_k      = r_k;
        n_deg    = r_deg;
        n_eye    = r_eye;
        n_wup    = r_wup;
        n_v      = r_v;
        n_neg    = r_neg;
        n_m      = r_m;
        n_x      = r_x;
        n_res    = r_res;
        n_rem    = r_rem;
        n_s      = r_s;
        n_q      = r_q;
        n_look   = r_look;
        n_rgt    = r_rgt;
        n_upv    = r_upv;
        n_r2     = r_r2;
        n_dot    = r_dot;
        n_acc    = r_acc;
        n_prod   = r_prod;
        o_pop    = 1'b0;
        op_a     = '0;
        op_b     = '0;
        mx       = '0;
        bitv     = '0;
        tdiv     = '0;
        accn     = '0;
        qz       = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop    = 1'b1;
                    n_eye[0] = i_job.item.eye_x;
                    n_eye[1] = i_job.item.eye_y;
                    n_eye[2] = i_job.item.eye_z;
                    n_wup[0] = i_job.item.up_x;
                    n_wup[1] = i_job.item.up_y;
                    n_wup[2] = i_job.item.up_z;
                    n_v[0]   = 64'(i_job.dx);
                    n_v[1]   = 64'(i_job.dy);
                    n_v[2]   = 64'(i_job.dz);
                    n_phase  = 2'd0;
                    n_deg    = 1'b0;
                    n_state  = S_ABS;
                end
            end

            S_ABS: begin
                mx = mabs[0];
                if (mabs[1] > mx) mx = mabs[1];
                if (mabs[2] > mx) mx = mabs[2];
                for (int i = 0; i < 3; i++) begin
                    n_m[i]   = mabs[i];
                    n_neg[i] = r_v[i][63];
                end
                if (mx == '0) begin
                    // zero-length vector: result is zero, flag it
                    for (int i = 0; i < 3; i++) begin
                        case (r_phase)
                            2'd0:    n_look[i] = '0;
                            2'd1:    n_rgt[i]  = '0;
                            default: n_upv[i]  = '0;
                        endcase
                    end
                    n_deg   = 1'b1;
                    n_cnt   = '0;
                    n_sub   = 1'b0;
                    n_acc   = '0;
                    n_state = S_CROSS;
                end else begin
                    n_state = S_SHIFT;
                end
            end

            S_SHIFT: begin
                mx = r_m[0];
                if (r_m[1] > mx) mx = r_m[1];
                if (r_m[2] > mx) mx = r_m[2];
                for (int i = 0; i < 3; i++) begin
                    if (mx >= (64'(1) << 38))      n_m[i] = r_m[i] >> 8;
                    else if (mx >= (64'(1) << 30)) n_m[i] = r_m[i] >> 1;
                    else if (mx < (64'(1) << 21))  n_m[i] = r_m[i] << 8;
                    else if (mx < (64'(1) << 29))  n_m[i] = r_m[i] << 1;
                end
                if (mx >= (64'(1) << 29) && mx < (64'(1) << 30)) begin
                    n_cnt   = '0;
                    n_sub   = 1'b0;
                    n_acc   = '0;
                    n_state = S_SQ;
                end
            end

            S_SQ: begin
                op_a = $signed({3'b000, r_m[r_cnt[1:0]][29:0]});
                op_b = op_a;
                if (!r_sub) begin
                    n_prod = prod[63:0];
                    n_sub  = 1'b1;
                end else begin
                    n_sub = 1'b0;
                    n_acc = r_acc + r_prod;
                    if (r_cnt == 3'd2) begin
                        n_x     = 64'(r_acc + r_prod);
                        n_res   = '0;
                        n_k     = 5'd31;
                        n_state = S_SQRT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end

            S_SQRT: begin
                bitv = 64'(1) << {r_k, 1'b0};
                if (r_x >= r_res + bitv) begin
                    n_x   = r_x - (r_res + bitv);
                    n_res = (r_res >> 1) + bitv;
                end else begin
                    n_res = r_res >> 1;
                end
                if (r_k == '0) begin
                    n_s     = n_res[31:0];
                    n_cnt   = '0;
                    n_sub   = 1'b0;
                    n_state = S_DIV;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end

            S_DIV: begin
                if (!r_sub) begin
                    n_rem = (r_m[r_cnt[1:0]] << FRAC_BITS) + 64'(r_s >> 1);
                    n_q   = '0;
                    n_k   = 5'(FRAC_BITS);
                    n_sub = 1'b1;
                end else begin
                    tdiv = 64'(r_s) << r_k;
                    if (r_rem >= tdiv) begin
                        n_rem      = r_rem - tdiv;
                        n_q[r_k[$clog2(QW)-1:0]] = 1'b1;
                    end
                    if (r_k == '0) begin
                        qz = 32'(n_q);
                        qz = r_neg[r_cnt[1:0]] ? 32'(0) - qz : qz;
                        case (r_phase)
                            2'd0:    n_look[r_cnt[1:0]] = qz;
                            2'd1:    n_rgt[r_cnt[1:0]]  = qz;
                            default: n_upv[r_cnt[1:0]]  = qz;
                        endcase
                        n_sub = 1'b0;
                        if (r_cnt == 3'd2) begin
                            n_cnt   = '0;
                            n_acc   = '0;
                            n_state = S_CROSS;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        n_k = r_k - 1'b1;
                    end
                end
            end

            S_CROSS: begin
                op_a = va[ia];
                op_b = vb[ib];
                if (!r_sub) begin
                    n_prod = prod[63:0];
                    n_sub  = 1'b1;
                end else begin
                    n_sub = 1'b0;
                    accn  = r_cnt[0] ? r_acc - r_prod : r_acc + r_prod;
                    n_acc = accn;
                    if (r_cnt[0]) begin
                        n_v[ci] = accn;
                        n_acc   = '0;
                    end
                    if (r_cnt == 3'd5) begin
                        n_cnt = '0;
                        if (r_phase == 2'd2) begin
                            n_state = S_ROUND;
                        end else begin
                            n_phase = r_phase + 1'b1;
                            n_state = S_ABS;
                        end
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end

            S_ROUND: begin
                for (int i = 0; i < 3; i++) begin
                    n_r2[i] = 32'(rnd(r_v[i]));
                end
                n_phase = 2'd0;
                n_cnt   = '0;
                n_sub   = 1'b0;
                n_acc   = '0;
                n_state = S_DOT;
            end

            S_DOT: begin
                op_a = 33'(r_eye[r_cnt[1:0]]);
                op_b = vd[r_cnt[1:0]];
                if (!r_sub) begin
                    n_prod = prod[63:0];
                    n_sub  = 1'b1;
                end else begin
                    n_sub = 1'b0;
                    accn  = r_acc + r_prod;
                    n_acc = accn;
                    if (r_cnt == 3'd2) begin
                        n_dot[r_phase] = negsat(accn);
                        n_acc          = '0;
                        n_cnt          = '0;
                        if (r_phase == 2'd2) begin
                            n_state = S_EMIT;
                        end else begin
                            n_phase = r_phase + 1'b1;
                        end
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end

            S_EMIT: begin
                n_strobe             = 1'b1;
                n_out.row_index      = r_cnt[1:0];
                n_out.degenerate     = r_deg;
                if (r_cnt == 3'd3) begin
                    n_out.col0     = r_dot[0];
                    n_out.col1     = r_dot[1];
                    n_out.col2     = r_dot[2];
                    n_out.col3     = 32'(1) << FRAC_BITS;
                    n_out.last_row = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_out.col0     = r_r2[r_cnt[1:0]];
                    n_out.col1     = r_upv[r_cnt[1:0]];
                    n_out.col2     = r_look[r_cnt[1:0]];
                    n_out.col3     = '0;
                    n_out.last_row = 1'b0;
                    n_cnt          = r_cnt + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_phase <= n_phase;
        r_cnt   <= n_cnt;
        r_sub   <= n_sub;
        r_k     <= n_k;
        r_deg   <= n_deg;
        r_eye   <= n_eye;
        r_wup   <= n_wup;
        r_v     <= n_v;
        r_neg   <= n_neg;
        r_m     <= n_m;
        r_x     <= n_x;
        r_res   <= n_res;
        r_rem   <= n_rem;
        r_s     <= n_s;
        r_q     <= n_q;
        r_look  <= n_look;
        r_rgt   <= n_rgt;
        r_upv   <= n_upv;
        r_r2    <= n_r2;
        r_dot   <= n_dot;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
